>>> rtl/core/rce_pkg.sv
package rce_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 32;
  localparam int BASE_BITS  = 6;
  localparam int CHAR_BITS  = 8;
  localparam int DVAL_BITS  = 7;

  // remainder is always below the output base, which is at most 36
  localparam int REM_BITS   = 6;

  // quotient bits produced per cycle by the divider
  localparam int STEP_BITS  = 4;
  localparam int DIV_CYCLES = VALUE_BITS / STEP_BITS;
  localparam int CNT_BITS   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam int NUM_BITS   = $clog2(MAX_DIGITS + 1);
  localparam int IDX_BITS   = $clog2(MAX_DIGITS);

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IN_BASE  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_BASE = 1'd1;

  localparam logic [BASE_BITS-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;

  localparam logic [DVAL_BITS-1:0] DVAL_BAD = 7'd64;

  localparam logic [CHAR_BITS-1:0] ASCII_0  = 8'h30;
  localparam logic [CHAR_BITS-1:0] ASCII_9  = 8'h39;
  localparam logic [CHAR_BITS-1:0] ASCII_UA = 8'h41;
  localparam logic [CHAR_BITS-1:0] ASCII_UZ = 8'h5A;
  localparam logic [CHAR_BITS-1:0] ASCII_LA = 8'h61;
  localparam logic [CHAR_BITS-1:0] ASCII_LZ = 8'h7A;
  localparam logic [CHAR_BITS-1:0] TEN      = 8'd10;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_in;
    logic                 char_last;
  } char_item_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 digit_last;
    logic                 bad_digit;
  } digit_item_t;

  function automatic logic [BASE_BITS-1:0] clamp_base(input logic [BASE_BITS-1:0] b);
    logic [BASE_BITS-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

  // digit value of a character, DVAL_BAD when not alphanumeric
  function automatic logic [DVAL_BITS-1:0] char_value(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] t;
    t = '0;
    if (c >= ASCII_0 && c <= ASCII_9) begin
      t = c - ASCII_0;
    end else if (c >= ASCII_UA && c <= ASCII_UZ) begin
      t = c - ASCII_UA + TEN;
    end else if (c >= ASCII_LA && c <= ASCII_LZ) begin
      t = c - ASCII_LA + TEN;
    end else begin
      t = {1'b0, DVAL_BAD};
    end
    return t[DVAL_BITS-1:0];
  endfunction

  function automatic logic [CHAR_BITS-1:0] digit_ascii(input logic [REM_BITS-1:0] d);
    logic [CHAR_BITS-1:0] w;
    w = {{(CHAR_BITS-REM_BITS){1'b0}}, d};
    if (w > TEN - 8'd1) return w - TEN + ASCII_UA;
    else return w + ASCII_0;
  endfunction

endpackage

>>> rtl/core/radix_conversion_engine_core.sv
// Channel   Ports                          Handshake
// input     start, busy, item              taken when start & !busy
// config    cfg_we, cfg_index, cfg_data    written when cfg_we
// result    digit_valid, digit             one-cycle strobe per item
//
// A character that is not marked last is taken while idle; busy stays low.
// The last character starts the conversion into D output digits (up to 32):
// the shared divider retires 4 quotient bits a cycle, with a store step after
// each digit; then each digit is read from the remainder memory and output.
// rst is synchronous; it restores both bases to 10 and clears the value.
// The receiver cannot stall; each result is shown for exactly one cycle.
module radix_conversion_engine_core
  import rce_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  char_item_t              item,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [BASE_BITS-1:0]    cfg_data,
  output logic                    digit_valid,
  output digit_item_t             digit
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]            state;
  logic [BASE_BITS-1:0]  in_base;
  logic [BASE_BITS-1:0]  out_base;
  logic [VALUE_BITS-1:0] acc;
  logic                  err;
  logic [REM_BITS-1:0]   rem;
  logic [CNT_BITS-1:0]   cnt;
  logic [NUM_BITS-1:0]   num;
  logic [IDX_BITS-1:0]   idx;
  logic [REM_BITS-1:0]   rd_data;
  logic [REM_BITS-1:0]   rem_store [MAX_DIGITS];

  logic [BASE_BITS-1:0]            ib;
  logic [BASE_BITS-1:0]            ob;
  logic [DVAL_BITS-1:0]            dval;
  logic                            dval_ok;
  logic [VALUE_BITS+BASE_BITS-1:0] prod;
  logic [VALUE_BITS-1:0]           acc_mac;
  logic [REM_BITS-1:0]             div_rem;
  logic [STEP_BITS-1:0]            div_q;
  logic [NUM_BITS-1:0]             num_next;
  logic                            accept;

  assign ib      = clamp_base(in_base);
  assign ob      = clamp_base(out_base);
  assign dval    = char_value(item.char_in);
  assign dval_ok = dval < {1'b0, ib};
  assign prod    = {{BASE_BITS{1'b0}}, acc} * {{VALUE_BITS{1'b0}}, ib};
  assign acc_mac = prod[VALUE_BITS-1:0] + {{(VALUE_BITS-DVAL_BITS){1'b0}}, dval};
  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;

  // drop digits beyond the store: only the least significant ones are kept
  assign num_next = (num < NUM_BITS'(MAX_DIGITS)) ? num + NUM_BITS'(1) : num;

  // restoring division, STEP_BITS bits from the top of acc per cycle
  always_comb begin
    logic [REM_BITS:0] trial;
    div_rem = rem;
    div_q   = '0;
    trial   = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {div_rem, acc[VALUE_BITS-1-i]};
      if (trial >= {1'b0, ob}) begin
        trial = trial - {1'b0, ob};
        div_q[STEP_BITS-1-i] = 1'b1;
      end
      div_rem = trial[REM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_base  <= BASE_RESET;
      out_base <= BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_BASE:  in_base  <= cfg_data;
        CFG_OUT_BASE: out_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_STORE && num < NUM_BITS'(MAX_DIGITS)) begin
      rem_store[num[IDX_BITS-1:0]] <= rem;
    end
    if (state == ST_READ) begin
      rd_data <= rem_store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      acc         <= '0;
      err         <= 1'b0;
      rem         <= '0;
      cnt         <= '0;
      num         <= '0;
      idx         <= '0;
      digit_valid <= 1'b0;
    end else begin
      digit_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (dval_ok) acc <= acc_mac;
            else err <= 1'b1;
            if (item.char_last) begin
              rem   <= '0;
              cnt   <= '0;
              num   <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // quotient bits shift in at the bottom; acc ends as the quotient
          acc <= {acc[VALUE_BITS-STEP_BITS-1:0], div_q};
          rem <= div_rem;
          cnt <= cnt + CNT_BITS'(1);
          if (cnt == CNT_BITS'(DIV_CYCLES - 1)) state <= ST_STORE;
        end
        ST_STORE: begin
          num <= num_next;
          rem <= '0;
          cnt <= '0;
          if (acc == '0) begin
            idx   <= IDX_BITS'(num_next - NUM_BITS'(1));
            state <= ST_READ;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_READ: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          digit_valid      <= 1'b1;
          digit.digit_char <= digit_ascii(rd_data);
          digit.digit_last <= (idx == '0);
          digit.bad_digit  <= err;
          if (idx == '0) begin
            err   <= 1'b0;
            state <= ST_IDLE;
          end else begin
            idx   <= idx - IDX_BITS'(1);
            state <= ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
